// ----- sv/frame_rate_pacer_with_skip_top_assert.svh -----
// Assertion macros used by the frame rate pacer top module.
`ifndef FRAME_RATE_PACER_WITH_SKIP_TOP_ASSERT_SVH
`define FRAME_RATE_PACER_WITH_SKIP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/frp_pkg.sv -----
// Package of the frame rate pacer: widths, reset values, microcode and its types.
package frp_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned TIME_W           = 32;
    localparam int unsigned FPS_W            = 10;
    localparam int unsigned SKIP_W           = 8;
    localparam int unsigned STAT_W           = 16;
    localparam int unsigned TPS_W_DEF        = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned DIV_W_DEF        = TPS_W_DEF + TIME_W;

    localparam logic [FPS_W-1:0]  FPS_RESET  = 10'd25;
    localparam logic [SKIP_W-1:0] SKIP_RESET = 8'd2;

    // Speed percent numerator: a saturated 16-bit count times 100.
    localparam int unsigned SPD_NUM_W       = 23;
    localparam logic [6:0]  PCT_SCALE       = 7'd100;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TARGET_FPS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_SKIP   = 2'd1;

    localparam int unsigned PC_W = 5;

    // Program steps.
    localparam logic [PC_W-1:0] S_IDLE      = 5'd0;
    localparam logic [PC_W-1:0] S_PREP      = 5'd1;
    localparam logic [PC_W-1:0] S_PACE      = 5'd2;
    localparam logic [PC_W-1:0] S_COUNT     = 5'd3;
    localparam logic [PC_W-1:0] S_MUL       = 5'd4;
    localparam logic [PC_W-1:0] S_CMP_EQ    = 5'd5;
    localparam logic [PC_W-1:0] S_CMP_LT    = 5'd6;
    localparam logic [PC_W-1:0] S_DUE_START = 5'd7;
    localparam logic [PC_W-1:0] S_DUE_LOOP  = 5'd8;
    localparam logic [PC_W-1:0] S_WAIT_CALC = 5'd9;
    localparam logic [PC_W-1:0] S_FTIME     = 5'd10;
    localparam logic [PC_W-1:0] S_ON_TARGET = 5'd11;
    localparam logic [PC_W-1:0] S_BEHIND    = 5'd12;
    localparam logic [PC_W-1:0] S_SEC       = 5'd13;
    localparam logic [PC_W-1:0] S_CLOSE     = 5'd14;
    localparam logic [PC_W-1:0] S_SPD_LOOP  = 5'd15;
    localparam logic [PC_W-1:0] S_SPEED     = 5'd16;
    localparam logic [PC_W-1:0] S_SPD100    = 5'd17;
    localparam logic [PC_W-1:0] S_EMIT      = 5'd18;
    localparam logic [PC_W-1:0] S_RETURN    = 5'd19;
    localparam logic [PC_W-1:0] S_FIRST     = 5'd20;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_PREP,
        OP_COUNT,
        OP_MUL,
        OP_DUE_START,
        OP_DIV_STEP,
        OP_WAIT,
        OP_FTIME,
        OP_RESTART,
        OP_BEHIND,
        OP_CLOSE,
        OP_SPEED,
        OP_SPEED100,
        OP_EMIT,
        OP_FIRST
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_NOT_STARTED,
        C_FPS_ZERO,
        C_EQUAL,
        C_BEHIND,
        C_DIV_MORE,
        C_NO_CLOSE,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    // Control store. When the condition holds the step counter jumps to the
    // target, otherwise it moves to the next step.
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{OP_NONE, C_ALWAYS, S_IDLE};
        case (pc)
            S_IDLE:      w = '{OP_CAPTURE,   C_NO_IN,       S_IDLE};
            S_PREP:      w = '{OP_PREP,      C_NOT_STARTED, S_FIRST};
            S_PACE:      w = '{OP_NONE,      C_FPS_ZERO,    S_SEC};
            S_COUNT:     w = '{OP_COUNT,     C_NEVER,       S_IDLE};
            S_MUL:       w = '{OP_MUL,       C_NEVER,       S_IDLE};
            S_CMP_EQ:    w = '{OP_NONE,      C_EQUAL,       S_ON_TARGET};
            S_CMP_LT:    w = '{OP_NONE,      C_BEHIND,      S_BEHIND};
            S_DUE_START: w = '{OP_DUE_START, C_NEVER,       S_IDLE};
            S_DUE_LOOP:  w = '{OP_DIV_STEP,  C_DIV_MORE,    S_DUE_LOOP};
            S_WAIT_CALC: w = '{OP_WAIT,      C_NEVER,       S_IDLE};
            S_FTIME:     w = '{OP_FTIME,     C_ALWAYS,      S_SEC};
            S_ON_TARGET: w = '{OP_RESTART,   C_ALWAYS,      S_SEC};
            S_BEHIND:    w = '{OP_BEHIND,    C_NEVER,       S_IDLE};
            S_SEC:       w = '{OP_NONE,      C_NO_CLOSE,    S_EMIT};
            S_CLOSE:     w = '{OP_CLOSE,     C_FPS_ZERO,    S_SPD100};
            S_SPD_LOOP:  w = '{OP_DIV_STEP,  C_DIV_MORE,    S_SPD_LOOP};
            S_SPEED:     w = '{OP_SPEED,     C_ALWAYS,      S_EMIT};
            S_SPD100:    w = '{OP_SPEED100,  C_NEVER,       S_IDLE};
            S_EMIT:      w = '{OP_EMIT,      C_OUT_FULL,    S_EMIT};
            S_RETURN:    w = '{OP_NONE,      C_ALWAYS,      S_IDLE};
            S_FIRST:     w = '{OP_FIRST,     C_ALWAYS,      S_EMIT};
            default:     w = '{OP_NONE,      C_ALWAYS,      S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/frp_ifs.sv -----
// Channel interfaces of the frame rate pacer: frame input, result output, configuration.
interface frp_in_if;
    logic                        valid;
    logic                        ready;
    logic [frp_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface frp_out_if;
    logic                        valid;
    logic                        ready;
    logic [frp_pkg::TIME_W-1:0]  frame_time_ms;
    logic [frp_pkg::TIME_W-1:0]  wait_ms;
    logic                        skip_draw;
    logic                        stats_valid;
    logic [frp_pkg::STAT_W-1:0]  measured_fps;
    logic [frp_pkg::STAT_W-1:0]  speed_percent;

    modport source (output valid, output frame_time_ms, output wait_ms, output skip_draw,
                    output stats_valid, output measured_fps, output speed_percent,
                    input ready);
    modport sink   (input valid, input frame_time_ms, input wait_ms, input skip_draw,
                    input stats_valid, input measured_fps, input speed_percent,
                    output ready);
endinterface

interface frp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [frp_pkg::CFG_ADDR_W-1:0]  addr;
    logic [frp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- sv/frp_div.sv -----
// Restoring divider that retires two quotient bits per step.
module frp_div #(
    parameter int unsigned DIV_W = frp_pkg::DIV_W_DEF,
    parameter int unsigned DEN_W = frp_pkg::FPS_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  frp_pkg::div_ctl_t ctl,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              more
);

    localparam int unsigned STEPS = (DIV_W + 1) / 2;
    localparam int unsigned SH_W  = 2 * STEPS;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS - 1);

    logic [SH_W-1:0]  q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DEN_W:0]   r1, r2, d1, d2;
    logic             ge1, ge2;
    logic [DEN_W-1:0] rem1, rem2;

    always_comb begin
        r1   = {rem_reg, q_reg[SH_W-1]};
        ge1  = r1 >= {1'b0, den_reg};
        d1   = r1 - {1'b0, den_reg};
        rem1 = ge1 ? d1[DEN_W-1:0] : r1[DEN_W-1:0];
        r2   = {rem1, q_reg[SH_W-2]};
        ge2  = r2 >= {1'b0, den_reg};
        d2   = r2 - {1'b0, den_reg};
        rem2 = ge2 ? d2[DEN_W-1:0] : r2[DEN_W-1:0];

        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (ctl.load) begin
            q_next   = SH_W'(dividend);
            rem_next = '0;
            den_next = divisor;
            cnt_next = '0;
        end else if (ctl.step) begin
            q_next   = {q_reg[SH_W-3:0], ge1, ge2};
            rem_next = rem2;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = q_reg[DIV_W-1:0];
    assign more     = cnt_reg != LAST_CNT;

endmodule

// ----- sv/frame_rate_pacer_with_skip_top.sv -----
// Frame rate pacer with frame skipping. Each frame transaction carries a frame-start
// time in ticks; the block answers with exactly one result transaction giving the
// frame time, the wait to insert, whether to skip drawing, and once per second the
// frame count and speed in percent. A small microcoded sequencer works on one frame
// at a time and the next frame is taken once the result sits in the output register.
// N = ceil((clog2(TICKS_PER_SECOND+1) + 32) / 2) (21 at 1000 ticks per second) is the
// step count of the shared two-bit-per-cycle divider, which forms both the due time
// of a frame that is ahead and, when a one-second window closes with a nonzero
// target, the speed percent. Writing a register with a new value clears the pacing
// state; the configuration port is always ready.
`include "frame_rate_pacer_with_skip_top_assert.svh"

module frame_rate_pacer_with_skip_top #(
    parameter int unsigned TICKS_PER_SECOND = frp_pkg::TICKS_PER_SECOND
) (
    input  logic      clk,
    input  logic      rst_n,
    frp_in_if.sink    frame,
    frp_out_if.source result,
    frp_cfg_if.sink   cfg
);

    localparam int unsigned TIME_W = frp_pkg::TIME_W;
    localparam int unsigned FPS_W  = frp_pkg::FPS_W;
    localparam int unsigned SKIP_W = frp_pkg::SKIP_W;
    localparam int unsigned STAT_W = frp_pkg::STAT_W;
    localparam int unsigned PC_W   = frp_pkg::PC_W;
    localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned DIV_W  = TPS_W + TIME_W;
    localparam int unsigned RHS_W  = FPS_W + TIME_W;
    localparam int unsigned CMP_W  = (DIV_W > RHS_W) ? DIV_W : RHS_W;
    localparam logic [TPS_W-1:0]  TPS_VAL  = TPS_W'(TICKS_PER_SECOND);
    localparam logic [TIME_W-1:0] TPS_TIME = TIME_W'(TICKS_PER_SECOND);

    // Sequencer and configuration.
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [FPS_W-1:0]  fps_reg, fps_next;
    logic [SKIP_W-1:0] max_skip_reg, max_skip_next;

    // Pacing state.
    logic              started_reg, started_next;
    logic [TIME_W-1:0] pws_reg, pws_next;
    logic [TIME_W-1:0] pcount_reg, pcount_next;
    logic [SKIP_W-1:0] skip_run_reg, skip_run_next;
    logic [TIME_W-1:0] sws_reg, sws_next;
    logic [STAT_W-1:0] sfc_reg, sfc_next;
    logic [TIME_W-1:0] last_reg, last_next;

    // Working registers of the current frame.
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] frame_dt_reg, frame_dt_next;
    logic [TIME_W-1:0] wait_reg, wait_next;
    logic [TIME_W-1:0] ftime_reg, ftime_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [DIV_W-1:0]  lhs_reg, lhs_next;
    logic [RHS_W-1:0]  rhs_reg, rhs_next;
    logic              stats_reg, stats_next;
    logic [STAT_W-1:0] mfps_reg, mfps_next;
    logic [STAT_W-1:0] speed_reg, speed_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_dt_reg;
    logic [TIME_W-1:0] out_wait_reg;
    logic              out_skip_reg;
    logic              out_stats_reg;
    logic [STAT_W-1:0] out_mfps_reg;
    logic [STAT_W-1:0] out_speed_reg;

    frp_pkg::ctrl_word_t ctrl;
    frp_pkg::div_ctl_t   div_ctl;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_quotient;
    logic                div_more;

    logic                        in_acc;
    logic                        out_full;
    logic                        out_load;
    logic                        cfg_wr;
    logic                        cfg_clear;
    logic                        jump;
    logic [CMP_W-1:0]            lhs_ext, rhs_ext;
    logic [TIME_W-1:0]           sec_dt;
    logic [DIV_W:0]              due_diff;
    logic [frp_pkg::SPD_NUM_W-1:0] spd_num;

    assign ctrl     = frp_pkg::ucode_rom(pc_reg);
    assign in_acc   = frame.valid && frame.ready;
    assign out_full = out_valid_reg && !result.ready;
    assign out_load = (ctrl.op == frp_pkg::OP_EMIT) && !out_full;
    assign cfg_wr   = cfg.valid && cfg.ready;
    assign lhs_ext  = CMP_W'(lhs_reg);
    assign rhs_ext  = CMP_W'(rhs_reg);
    assign sec_dt   = ftime_reg - sws_reg;
    assign due_diff = {1'b0, div_quotient} - {1'b0, DIV_W'(elapsed_reg)};
    assign spd_num  = frp_pkg::SPD_NUM_W'(sfc_reg) * frp_pkg::SPD_NUM_W'(frp_pkg::PCT_SCALE);

    always_comb begin
        cfg_clear = 1'b0;
        if (cfg_wr) begin
            if (cfg.addr == frp_pkg::CFG_IDX_TARGET_FPS) begin
                cfg_clear = cfg.data[FPS_W-1:0] != fps_reg;
            end else if (cfg.addr == frp_pkg::CFG_IDX_MAX_SKIP) begin
                cfg_clear = cfg.data[SKIP_W-1:0] != max_skip_reg;
            end
        end
    end

    always_comb begin
        case (ctrl.cond)
            frp_pkg::C_NEVER:       jump = 1'b0;
            frp_pkg::C_ALWAYS:      jump = 1'b1;
            frp_pkg::C_NO_IN:       jump = !frame.valid;
            frp_pkg::C_NOT_STARTED: jump = !started_reg;
            frp_pkg::C_FPS_ZERO:    jump = fps_reg == '0;
            frp_pkg::C_EQUAL:       jump = lhs_ext == rhs_ext;
            frp_pkg::C_BEHIND:      jump = lhs_ext < rhs_ext;
            frp_pkg::C_DIV_MORE:    jump = div_more;
            frp_pkg::C_NO_CLOSE:    jump = sec_dt < TPS_TIME;
            frp_pkg::C_OUT_FULL:    jump = out_full;
            default:                jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    always_comb begin
        div_ctl.load = (ctrl.op == frp_pkg::OP_DUE_START) || (ctrl.op == frp_pkg::OP_CLOSE);
        div_ctl.step = ctrl.op == frp_pkg::OP_DIV_STEP;
        div_dividend = (ctrl.op == frp_pkg::OP_CLOSE) ? DIV_W'(spd_num) : lhs_reg;
    end

    always_comb begin
        fps_next      = fps_reg;
        max_skip_next = max_skip_reg;
        started_next  = started_reg;
        pws_next      = pws_reg;
        pcount_next   = pcount_reg;
        skip_run_next = skip_run_reg;
        sws_next      = sws_reg;
        sfc_next      = sfc_reg;
        last_next     = last_reg;
        now_next      = now_reg;
        frame_dt_next = frame_dt_reg;
        wait_next     = wait_reg;
        ftime_next    = ftime_reg;
        elapsed_next  = elapsed_reg;
        lhs_next      = lhs_reg;
        rhs_next      = rhs_reg;
        stats_next    = stats_reg;
        mfps_next     = mfps_reg;
        speed_next    = speed_reg;

        case (ctrl.op)
            frp_pkg::OP_CAPTURE: begin
                if (in_acc) begin
                    now_next = frame.now_ms;
                end
            end
            frp_pkg::OP_PREP: begin
                frame_dt_next = now_reg - last_reg;
                if (sfc_reg != '1) begin
                    sfc_next = sfc_reg + 1'b1;
                end
                elapsed_next = now_reg - pws_reg;
                ftime_next   = now_reg;
                wait_next    = '0;
                stats_next   = 1'b0;
                mfps_next    = '0;
                speed_next   = '0;
            end
            frp_pkg::OP_COUNT: begin
                pcount_next = pcount_reg + 1'b1;
            end
            frp_pkg::OP_MUL: begin
                lhs_next = DIV_W'(TPS_VAL) * DIV_W'(pcount_reg);
                rhs_next = RHS_W'(fps_reg) * RHS_W'(elapsed_reg);
            end
            frp_pkg::OP_DUE_START: begin
                skip_run_next = '0;
            end
            frp_pkg::OP_WAIT: begin
                // A due time at or before the elapsed time asks for no wait.
                if (due_diff[DIV_W]) begin
                    wait_next = '0;
                end else if (|due_diff[DIV_W-1:TIME_W]) begin
                    wait_next = '1;
                end else begin
                    wait_next = due_diff[TIME_W-1:0];
                end
            end
            frp_pkg::OP_FTIME: begin
                ftime_next = now_reg + wait_reg;
            end
            frp_pkg::OP_RESTART: begin
                pws_next      = now_reg;
                pcount_next   = '0;
                skip_run_next = '0;
            end
            frp_pkg::OP_BEHIND: begin
                if (skip_run_reg < max_skip_reg) begin
                    skip_run_next = skip_run_reg + 1'b1;
                end else begin
                    pws_next      = now_reg;
                    pcount_next   = '0;
                    skip_run_next = '0;
                end
            end
            frp_pkg::OP_CLOSE: begin
                stats_next = 1'b1;
                mfps_next  = sfc_reg;
                sws_next   = ftime_reg;
                sfc_next   = '0;
            end
            frp_pkg::OP_SPEED: begin
                speed_next = (|div_quotient[DIV_W-1:STAT_W]) ? '1 : div_quotient[STAT_W-1:0];
            end
            frp_pkg::OP_SPEED100: begin
                speed_next = STAT_W'(frp_pkg::PCT_SCALE);
            end
            frp_pkg::OP_EMIT: begin
                if (out_load) begin
                    last_next = ftime_reg;
                end
            end
            frp_pkg::OP_FIRST: begin
                started_next  = 1'b1;
                pws_next      = now_reg;
                sws_next      = now_reg;
                pcount_next   = '0;
                sfc_next      = '0;
                skip_run_next = '0;
                ftime_next    = now_reg;
                frame_dt_next = '0;
            end
            default: begin
            end
        endcase

        if (cfg_wr && (cfg.addr == frp_pkg::CFG_IDX_TARGET_FPS)) begin
            fps_next = cfg.data[FPS_W-1:0];
        end
        if (cfg_wr && (cfg.addr == frp_pkg::CFG_IDX_MAX_SKIP)) begin
            max_skip_next = cfg.data[SKIP_W-1:0];
        end
        if (cfg_clear) begin
            started_next  = 1'b0;
            pws_next      = '0;
            pcount_next   = '0;
            skip_run_next = '0;
            sws_next      = '0;
            sfc_next      = '0;
            last_next     = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !result.ready;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pc_reg        <= frp_pkg::S_IDLE;
            fps_reg       <= frp_pkg::FPS_RESET;
            max_skip_reg  <= frp_pkg::SKIP_RESET;
            started_reg   <= 1'b0;
            pws_reg       <= '0;
            pcount_reg    <= '0;
            skip_run_reg  <= '0;
            sws_reg       <= '0;
            sfc_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            fps_reg       <= fps_next;
            max_skip_reg  <= max_skip_next;
            started_reg   <= started_next;
            pws_reg       <= pws_next;
            pcount_reg    <= pcount_next;
            skip_run_reg  <= skip_run_next;
            sws_reg       <= sws_next;
            sfc_reg       <= sfc_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        now_reg      <= now_next;
        frame_dt_reg <= frame_dt_next;
        wait_reg     <= wait_next;
        ftime_reg    <= ftime_next;
        elapsed_reg  <= elapsed_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        stats_reg    <= stats_next;
        mfps_reg     <= mfps_next;
        speed_reg    <= speed_next;
        if (out_load) begin
            out_dt_reg    <= frame_dt_reg;
            out_wait_reg  <= wait_reg;
            out_skip_reg  <= skip_run_reg != '0;
            out_stats_reg <= stats_reg;
            out_mfps_reg  <= mfps_reg;
            out_speed_reg <= speed_reg;
        end
    end

    frp_div #(
        .DIV_W (DIV_W),
        .DEN_W (FPS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (fps_reg),
        .quotient (div_quotient),
        .more     (div_more)
    );

    assign frame.ready          = pc_reg == frp_pkg::S_IDLE;
    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.frame_time_ms = out_dt_reg;
    assign result.wait_ms       = out_wait_reg;
    assign result.skip_draw     = out_skip_reg;
    assign result.stats_valid   = out_stats_reg;
    assign result.measured_fps  = out_mfps_reg;
    assign result.speed_percent = out_speed_reg;

    `FRP_ASSERT_NEXT(a_accept_starts_program, in_acc, pc_reg == frp_pkg::S_PREP, "accepted frame did not start the program")
    `FRP_ASSERT_NEXT(a_emit_fills_output, out_load, result.valid, "emitted result did not reach the output")
    `FRP_ASSERT_SAME(a_wait_only_unskipped, (pc_reg == frp_pkg::S_EMIT) && (wait_reg != '0), skip_run_reg == '0, "wait requested on a skipped frame")
    `FRP_ASSERT_SAME(a_skip_run_bounded, 1'b1, skip_run_reg <= max_skip_reg, "skip run exceeds the maximum")

endmodule
